// ===== sv/pru_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pru_pkg: shared types, constants and helpers
// widths, register codes and the result record of the pixel upscaler
// ----------------------------------------------------------------------------
package pru_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_SCALE   = 100;
  localparam int MAX_HEIGHT  = 4096;

  localparam int SCALE_W     = 7;
  localparam int DIM_W       = 13;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int PIX_W       = 24;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_W     = QUEUE_AW + 1;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_TICK  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    CFG_SCALE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic [SCALE_W-1:0] copies;
    logic [1:0]         pad;
    logic               row_end;
    logic               image_end;
    logic               dropped;
  } res_t;

  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
    logic [SCALE_W-1:0] r;
    if (v == '0) begin
      r = SCALE_W'(1);
    end else if (v > SCALE_W'(MAX_SCALE)) begin
      r = SCALE_W'(MAX_SCALE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // zero bytes that bring 3*s*w bytes up to a multiple of four
  function automatic logic [1:0] row_pad(input logic [1:0] s2, input logic [1:0] w2);
    logic [5:0] prod;
    prod = 6'(s2) * 6'(w2) * 6'd3;
    return 2'd0 - prod[1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/pru_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pru_front: item classification and line store
// tracks column, replay pass and source row, writes and replays the row
// ----------------------------------------------------------------------------
module pru_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      take_i,
  input  wire logic                      kind_i,
  input  wire logic [7:0]                blue_i,
  input  wire logic [7:0]                green_i,
  input  wire logic [7:0]                red_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [pru_pkg::DIM_W-1:0] cfg_data_i,
  output logic                           res_valid_o,
  output pru_pkg::res_t                  res_o
);

  logic [pru_pkg::SCALE_W-1:0] scale_q;
  logic [pru_pkg::DIM_W-1:0]   width_q, height_q;
  logic [pru_pkg::SCALE_W-1:0] s_eff;
  logic [pru_pkg::DIM_W-1:0]   w_eff, h_eff;
  logic [1:0]                  pad;

  logic [pru_pkg::COL_W-1:0]   col_q, col_d;
  logic [pru_pkg::SCALE_W-1:0] pass_q, pass_d;
  logic [pru_pkg::ROW_W-1:0]   row_q, row_d;
  logic                        replaying_q, replaying_d;

  logic [pru_pkg::COL_W:0]     col_inc;
  logic [pru_pkg::SCALE_W:0]   pass_inc;
  logic [pru_pkg::ROW_W:0]     row_inc;
  logic                        col_wrap, row_wrap;

  logic                        wr_en, rd_en;
  logic [pru_pkg::PIX_W-1:0]   mem_q;
  logic [pru_pkg::PIX_W-1:0]   line_mem [pru_pkg::MAX_WIDTH];

  logic                        vld_d, vld_q, use_mem_d, use_mem_q;
  pru_pkg::res_t               res_d, res_q;

  assign s_eff = pru_pkg::clamp_scale(scale_q);
  assign w_eff = pru_pkg::clamp_dim(width_q, pru_pkg::DIM_W'(pru_pkg::MAX_WIDTH));
  assign h_eff = pru_pkg::clamp_dim(height_q, pru_pkg::DIM_W'(pru_pkg::MAX_HEIGHT));
  assign pad   = pru_pkg::row_pad(s_eff[1:0], w_eff[1:0]);

  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign col_wrap = pru_pkg::DIM_W'(col_inc) >= w_eff;
  assign pass_inc = {1'b0, pass_q} + 1'b1;
  assign row_inc  = {1'b0, row_q} + 1'b1;
  assign row_wrap = pru_pkg::DIM_W'(row_inc) >= h_eff;

  always_comb begin
    col_d       = col_q;
    pass_d      = pass_q;
    row_d       = row_q;
    replaying_d = replaying_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    vld_d       = 1'b0;
    use_mem_d   = 1'b0;
    res_d       = '0;
    if (take_i) begin
      if (kind_i == pru_pkg::KIND_PIXEL) begin
        vld_d = 1'b1;
        if (replaying_q) begin
          res_d.dropped = 1'b1;
        end else begin
          wr_en        = 1'b1;
          res_d.blue   = blue_i;
          res_d.green  = green_i;
          res_d.red    = red_i;
          res_d.copies = s_eff;
          col_d        = col_inc[pru_pkg::COL_W-1:0];
          if (col_wrap) begin
            col_d         = '0;
            res_d.row_end = 1'b1;
            res_d.pad     = pad;
            if (s_eff > pru_pkg::SCALE_W'(1)) begin
              replaying_d = 1'b1;
              pass_d      = pru_pkg::SCALE_W'(1);
            end else begin
              row_d           = row_wrap ? '0 : row_inc[pru_pkg::ROW_W-1:0];
              res_d.image_end = row_wrap;
            end
          end
        end
      end else if (replaying_q) begin
        // tick: replay the stored pixel at the current column
        vld_d        = 1'b1;
        rd_en        = 1'b1;
        use_mem_d    = 1'b1;
        res_d.copies = s_eff;
        col_d        = col_inc[pru_pkg::COL_W-1:0];
        if (col_wrap) begin
          col_d         = '0;
          res_d.row_end = 1'b1;
          res_d.pad     = pad;
          pass_d        = pass_inc[pru_pkg::SCALE_W-1:0];
          if (pass_inc >= {1'b0, s_eff}) begin
            replaying_d     = 1'b0;
            pass_d          = '0;
            row_d           = row_wrap ? '0 : row_inc[pru_pkg::ROW_W-1:0];
            res_d.image_end = row_wrap;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= pru_pkg::SCALE_W'(1);
      width_q     <= pru_pkg::DIM_W'(1);
      height_q    <= pru_pkg::DIM_W'(1);
      col_q       <= '0;
      pass_q      <= '0;
      row_q       <= '0;
      replaying_q <= 1'b0;
      vld_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (pru_pkg::cfg_idx_e'(cfg_idx_i))
          pru_pkg::CFG_SCALE:  scale_q  <= cfg_data_i[pru_pkg::SCALE_W-1:0];
          pru_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
          pru_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      col_q       <= col_d;
      pass_q      <= pass_d;
      row_q       <= row_d;
      replaying_q <= replaying_d;
      vld_q       <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    use_mem_q <= use_mem_d;
  end

  // line store, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[col_q] <= {red_i, green_i, blue_i};
    end
    if (rd_en) begin
      mem_q <= line_mem[col_q];
    end
  end

  always_comb begin
    res_o = res_q;
    if (use_mem_q) begin
      res_o.red   = mem_q[23:16];
      res_o.green = mem_q[15:8];
      res_o.blue  = mem_q[7:0];
    end
  end

  assign res_valid_o = vld_q;

endmodule
`default_nettype wire

// ===== sv/pru_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pru_queue: result queue
// small flop queue between classification and the output channel
// ----------------------------------------------------------------------------
module pru_queue (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire pru_pkg::res_t               push_data_i,
  input  wire logic                        pop_i,
  output logic                             head_valid_o,
  output pru_pkg::res_t                    head_o,
  output logic [pru_pkg::LEVEL_W-1:0]      level_o
);

  pru_pkg::res_t                       slot_q [pru_pkg::QUEUE_DEPTH];
  logic [pru_pkg::QUEUE_AW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [pru_pkg::LEVEL_W-1:0]         level_q;
  logic                                do_pop;

  assign do_pop = pop_i && (level_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      level_q <= level_q + pru_pkg::LEVEL_W'(push_i) - pru_pkg::LEVEL_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_valid_o = (level_q != '0);
  assign head_o       = slot_q[rd_ptr_q];
  assign level_o      = level_q;

endmodule
`default_nettype wire

// ===== sv/pixel_replication_upscaler_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_replication_upscaler_top: integer nearest-neighbor upscaler
// source pixels are stored in a line buffer and replayed scale-1 times
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o, kind_i selects a source pixel or
//   a replay tick; a transfer takes place when valid is high and stall is low
//   output channel: out_valid_o / out_stall_i, one result per pixel, one per
//   tick during replay, none for a tick outside replay
//   config port: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 scale,
//   1 src width, 2 src height); user writes only while block is idle, unchecked
// timing
//   one item per cycle sustained while in_stall_o is low; a result shows on
//   the output after the classification stage and queue registers
//   the line store read lands together with the stage register
// reset
//   counters clear, registers go to 1, line store is not cleared
// stall
//   the 4-entry result queue accepts until it and the stage hold four entries;
//   in_stall_o is taken from registers only, never from out_stall_i
// ----------------------------------------------------------------------------
module pixel_replication_upscaler_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      kind_i,
  input  wire logic [7:0]                blue_in_i,
  input  wire logic [7:0]                green_in_i,
  input  wire logic [7:0]                red_in_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [7:0]                     blue_out_o,
  output logic [7:0]                     green_out_o,
  output logic [7:0]                     red_out_o,
  output logic [pru_pkg::SCALE_W-1:0]    copies_o,
  output logic [1:0]                     pad_bytes_o,
  output logic                           row_end_o,
  output logic                           image_end_o,
  output logic                           dropped_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [pru_pkg::DIM_W-1:0] cfg_data_i
);

  logic                           in_take;
  logic                           front_valid;
  pru_pkg::res_t                  front_res;
  pru_pkg::res_t                  head;
  logic [pru_pkg::LEVEL_W-1:0]    q_level;
  logic [pru_pkg::LEVEL_W:0]      in_flight;

  // stage and queue entries together never exceed the queue depth
  assign in_flight  = {1'b0, q_level} + (pru_pkg::LEVEL_W + 1)'(front_valid);
  assign in_stall_o = in_flight >= (pru_pkg::LEVEL_W + 1)'(pru_pkg::QUEUE_DEPTH);
  assign in_take    = in_valid_i && !in_stall_o;

  pru_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (in_take),
    .kind_i      (kind_i),
    .blue_i      (blue_in_i),
    .green_i     (green_in_i),
    .red_i       (red_in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (front_valid),
    .res_o       (front_res)
  );

  pru_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (front_valid),
    .push_data_i  (front_res),
    .pop_i        (!out_stall_i),
    .head_valid_o (out_valid_o),
    .head_o       (head),
    .level_o      (q_level)
  );

  // result fields straight from the queue head
  assign blue_out_o  = head.blue;
  assign green_out_o = head.green;
  assign red_out_o   = head.red;
  assign copies_o    = head.copies;
  assign pad_bytes_o = head.pad;
  assign row_end_o   = head.row_end;
  assign image_end_o = head.image_end;
  assign dropped_o   = head.dropped;

`ifndef ASSERT_OFF
  // queue never receives a push while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(front_valid && (q_level == pru_pkg::LEVEL_W'(pru_pkg::QUEUE_DEPTH))))
    else $error("result queue overflow");

  // a dropped pixel carries no copies and no row boundary
  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_o) |-> (copies_o == '0 && !row_end_o && !image_end_o))
    else $error("dropped result carries pixel data");

  // image end is always also a row end
  a_image_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && image_end_o) |-> row_end_o)
    else $error("image end without row end");

  // an empty pipeline never stalls the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_level == '0 && !front_valid) |-> !in_stall_o)
    else $error("input stalled while empty");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the pixel replication upscaler
// a short table of directed steps, then random phases of source rows and
// replay ticks under bursty input, random back-pressure and register changes;
// each result is checked in order against a behavioral predictor of the block
// ----------------------------------------------------------------------------
module tb_top;
  import pru_pkg::*;

  // an ignored tick leaves no result behind, so give the pipe time to empty
  localparam int IDLE_SETTLE  = 6;
  // cycles without any transfer or register write before giving up
  localparam int WATCHDOG_MAX = 3000;
  // random items to run, the long-replay phase included
  localparam int RANDOM_ITEMS = 1300;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  // one row of the directed table: a register write or an input transfer,
  // optionally with the result typed in by hand
  typedef struct {
    bit                 is_cfg;
    cfg_idx_e           idx;
    logic [DIM_W-1:0]   value;
    kind_e              kind;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    bit                 known;
    bit                 known_has;
    res_t               known_res;
  } plan_step_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               kind_i;
  logic [7:0]         blue_in_i;
  logic [7:0]         green_in_i;
  logic [7:0]         red_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         blue_out_o;
  logic [7:0]         green_out_o;
  logic [7:0]         red_out_o;
  logic [SCALE_W-1:0] copies_o;
  logic [1:0]         pad_bytes_o;
  logic               row_end_o;
  logic               image_end_o;
  logic               dropped_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [DIM_W-1:0]   cfg_data_i;

  pixel_replication_upscaler_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .blue_in_i   (blue_in_i),
    .green_in_i  (green_in_i),
    .red_in_i    (red_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .blue_out_o  (blue_out_o),
    .green_out_o (green_out_o),
    .red_out_o   (red_out_o),
    .copies_o    (copies_o),
    .pad_bytes_o (pad_bytes_o),
    .row_end_o   (row_end_o),
    .image_end_o (image_end_o),
    .dropped_o   (dropped_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // predictor state: a private copy of the line store, counters and registers
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] row_mem [MAX_WIDTH];
  int unsigned      stored_cols;   // entries of row_mem written so far, from 0 up
  int unsigned      col_pos;
  int unsigned      pass_cnt;
  int unsigned      src_row_cnt;
  bit               in_replay;
  logic [DIM_W-1:0] scale_reg;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;

  res_t             pending_pixels[$];   // expected results, oldest first

  int unsigned      burst_left;
  int unsigned      hold_requests;
  int unsigned      holds_served;
  int unsigned      mismatch_count;
  int unsigned      quiet_cycles;
  int unsigned      random_total;

  plan_step_t       directed_plan[$];

  function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic res_t mk_res(input logic [7:0] b, g, r, input int unsigned copies,
                                  input int unsigned pad, input bit re, ie, dr);
    res_t res;
    res.blue      = b;
    res.green     = g;
    res.red       = r;
    res.copies    = SCALE_W'(copies);
    res.pad       = 2'(pad);
    res.row_end   = re;
    res.image_end = ie;
    res.dropped   = dr;
    return res;
  endfunction

  // advance the predictor by one accepted item; returns 1 when a result is due
  function automatic bit upscale_predict(input kind_e k, input logic [7:0] b, g, r,
                                         output res_t res);
    int unsigned      s;
    int unsigned      w;
    int unsigned      h;
    int unsigned      pad;
    logic [PIX_W-1:0] pix;
    s   = clamp_to(scale_reg[SCALE_W-1:0], MAX_SCALE);
    w   = clamp_to(width_reg, MAX_WIDTH);
    h   = clamp_to(height_reg, MAX_HEIGHT);
    // zero bytes that round 3*s*w up to a multiple of four
    pad = (4 - ((3 * (s % 4) * (w % 4)) % 4)) % 4;
    res = '0;
    if (k == KIND_PIXEL) begin
      if (in_replay) begin
        // source pixel during replay is thrown away and flagged
        res.dropped = 1'b1;
        return 1'b1;
      end
      pix = {r, g, b};
      row_mem[col_pos] = pix;
      if (col_pos + 1 > stored_cols) begin
        stored_cols = col_pos + 1;
      end
    end else begin
      if (!in_replay) begin
        return 1'b0;
      end
      pix = row_mem[col_pos];
    end
    {res.red, res.green, res.blue} = pix;
    res.copies = SCALE_W'(s);
    col_pos++;
    if (col_pos >= w) begin
      col_pos     = 0;
      res.row_end = 1'b1;
      res.pad     = 2'(pad);
      if (k == KIND_PIXEL && s > 1) begin
        in_replay = 1'b1;
        pass_cnt  = 1;
      end else if (k == KIND_PIXEL || pass_cnt + 1 >= s) begin
        in_replay = 1'b0;
        pass_cnt  = 0;
        src_row_cnt++;
        if (src_row_cnt >= h) begin
          src_row_cnt   = 0;
          res.image_end = 1'b1;
        end
      end else begin
        pass_cnt++;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // input side: one transfer per call, in bursts of random length with
  // random gaps; the payload holds still while the block stalls
  // ---------------------------------------------------------------------------
  task automatic push_item(input kind_e k, input logic [7:0] b, g, r,
                           input bit known, input bit known_has, input res_t known_res,
                           output bit produced);
    int unsigned gap;
    res_t        res;
    bit          has;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    kind_i     <= k;
    blue_in_i  <= b;
    green_in_i <= g;
    red_in_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    has = upscale_predict(k, b, g, r, res);
    // hand-typed rows override the predictor, which still advances its state
    if (known) begin
      has = known_has;
      res = known_res;
    end
    if (has) begin
      pending_pixels.push_back(res);
    end
    produced = has;
  endtask

  // drop valid and wait for every expected result, plus the pipe depth
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (IDLE_SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DIM_W-1:0] value);
    bit drained;
    // widening the row during replay would read entries never written:
    // finish the replay first
    if (idx == CFG_WIDTH && in_replay && clamp_to(value, MAX_WIDTH) > stored_cols) begin
      while (in_replay) begin
        push_item(KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                  1'b0, 1'b0, '0, drained);
      end
    end
    settle_block();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_SCALE:  scale_reg  = value;
      CFG_WIDTH:  width_reg  = value;
      CFG_HEIGHT: height_reg = value;
      default: ;
    endcase
  endtask

  // mostly well-formed traffic: pixels outside replay, ticks during it,
  // with a few dropped pixels and ignored ticks mixed in
  task automatic random_item(output bit produced);
    kind_e k;
    if (in_replay) begin
      k = ($urandom_range(0, 99) < 92) ? KIND_TICK : KIND_PIXEL;
    end else begin
      k = ($urandom_range(0, 99) < 95) ? KIND_PIXEL : KIND_TICK;
    end
    push_item(k, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0, '0, produced);
  endtask

  task automatic run_phase(input int unsigned items);
    bit          produced;
    int unsigned n;
    n = 0;
    while (n < items) begin
      random_item(produced);
      if (produced) begin
        n++;
      end
    end
    random_total += n;
  endtask

  // new register settings for a phase; large scales keep rows narrow
  task automatic random_setup();
    logic [DIM_W-1:0] s_val;
    logic [DIM_W-1:0] w_val;
    logic [DIM_W-1:0] h_val;
    bit               put_s;
    bit               put_w;
    bit               put_h;
    int unsigned      roll;
    int unsigned      s_eff;
    put_s = ($urandom_range(0, 3) != 0);
    roll  = $urandom_range(0, 19);
    if (roll < 15) begin
      s_val = DIM_W'($urandom_range(1, 6));
    end else if (roll == 15) begin
      s_val = '0;
    end else if (roll == 16) begin
      s_val = DIM_W'(MAX_SCALE);
    end else begin
      s_val = DIM_W'($urandom_range(7, 8191));
    end
    s_eff = clamp_to(put_s ? s_val[SCALE_W-1:0] : scale_reg[SCALE_W-1:0], MAX_SCALE);
    roll  = $urandom_range(0, 19);
    if (s_eff > 8) begin
      w_val = DIM_W'($urandom_range(0, 3));
    end else if (roll == 0) begin
      w_val = '0;
    end else begin
      w_val = DIM_W'($urandom_range(1, 9));
    end
    put_w = (s_eff > 8) || ($urandom_range(0, 3) != 0);
    roll  = $urandom_range(0, 19);
    h_val = (roll == 0) ? DIM_W'(8191) : DIM_W'($urandom_range(0, 5));
    put_h = ($urandom_range(0, 3) != 0);
    if (put_s) write_reg(CFG_SCALE, s_val);
    if (put_w) write_reg(CFG_WIDTH, w_val);
    if (put_h) write_reg(CFG_HEIGHT, h_val);
  endtask

  function automatic plan_step_t plan_item(input kind_e k, input logic [7:0] b, g, r,
                                           input bit known, input bit known_has,
                                           input res_t known_res);
    plan_step_t st;
    st.is_cfg    = 1'b0;
    st.idx       = CFG_NONE;
    st.value     = '0;
    st.kind      = k;
    st.blue      = b;
    st.green     = g;
    st.red       = r;
    st.known     = known;
    st.known_has = known_has;
    st.known_res = known_res;
    return st;
  endfunction

  function automatic plan_step_t plan_cfg(input cfg_idx_e idx, input logic [DIM_W-1:0] v);
    plan_step_t st;
    st        = plan_item(KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0);
    st.is_cfg = 1'b1;
    st.idx    = idx;
    st.value  = v;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    bit produced;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_PIXEL;
    blue_in_i      = '0;
    green_in_i     = '0;
    red_in_i       = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_NONE;
    cfg_data_i     = '0;
    col_pos        = 0;
    pass_cnt       = 0;
    src_row_cnt    = 0;
    in_replay      = 1'b0;
    stored_cols    = 0;
    scale_reg      = DIM_W'(1);
    width_reg      = DIM_W'(1);
    height_reg     = DIM_W'(1);
    burst_left     = 0;
    hold_requests  = 0;
    random_total   = 0;

    // after reset: scale 1, one-pixel rows, one-row images, so every pixel
    // closes the image and carries one pad byte
    directed_plan.push_back(plan_item(KIND_PIXEL, 8'hff, 8'h00, 8'hff, 1'b1, 1'b1,
                                      mk_res(8'hff, 8'h00, 8'hff, 1, 1, 1'b1, 1'b1, 1'b0)));
    directed_plan.push_back(plan_item(KIND_PIXEL, 8'h00, 8'hff, 8'h00, 1'b1, 1'b1,
                                      mk_res(8'h00, 8'hff, 8'h00, 1, 1, 1'b1, 1'b1, 1'b0)));
    // tick outside replay gives nothing
    directed_plan.push_back(plan_item(KIND_TICK, 8'h5a, 8'ha5, 8'h3c, 1'b1, 1'b0, '0));
    directed_plan.push_back(plan_cfg(CFG_SCALE, DIM_W'(2)));
    directed_plan.push_back(plan_cfg(CFG_HEIGHT, DIM_W'(2)));
    directed_plan.push_back(plan_item(KIND_PIXEL, 8'h12, 8'h34, 8'h56, 1'b0, 1'b0, '0));
    // pixel during replay: all fields zero but the drop flag
    directed_plan.push_back(plan_item(KIND_PIXEL, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1,
                                      mk_res(8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0, 1'b1)));
    directed_plan.push_back(plan_item(KIND_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0));
    directed_plan.push_back(plan_item(KIND_TICK, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, '0));
    directed_plan.push_back(plan_item(KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0));
    directed_plan.push_back(plan_item(KIND_TICK, 8'h0f, 8'hf0, 8'h81, 1'b0, 1'b0, '0));
    // out-of-range register values clamp; index 3 writes nothing
    directed_plan.push_back(plan_cfg(CFG_WIDTH, DIM_W'(8191)));
    directed_plan.push_back(plan_cfg(CFG_WIDTH, DIM_W'(0)));
    directed_plan.push_back(plan_cfg(CFG_SCALE, DIM_W'(8191)));
    directed_plan.push_back(plan_cfg(CFG_HEIGHT, DIM_W'(MAX_HEIGHT)));
    directed_plan.push_back(plan_cfg(CFG_NONE, DIM_W'(8191)));
    // largest scale: copies 100, no padding since 3*100 is a multiple of four
    directed_plan.push_back(plan_item(KIND_PIXEL, 8'ha5, 8'h5a, 8'hc3, 1'b1, 1'b1,
                                      mk_res(8'ha5, 8'h5a, 8'hc3, 100, 0, 1'b1, 1'b0, 1'b0)));
    directed_plan.push_back(plan_item(KIND_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0));
    directed_plan.push_back(plan_item(KIND_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0));
    // shrinking scale mid replay ends the replay at the next row end
    directed_plan.push_back(plan_cfg(CFG_SCALE, DIM_W'(0)));
    directed_plan.push_back(plan_item(KIND_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0));
    // row count already past the new height: the next row closes the image
    directed_plan.push_back(plan_cfg(CFG_HEIGHT, DIM_W'(1)));
    directed_plan.push_back(plan_item(KIND_PIXEL, 8'h3c, 8'hc3, 8'h7e, 1'b0, 1'b0, '0));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        write_reg(directed_plan[i].idx, directed_plan[i].value);
      end else begin
        push_item(directed_plan[i].kind, directed_plan[i].blue, directed_plan[i].green,
                  directed_plan[i].red, directed_plan[i].known, directed_plan[i].known_has,
                  directed_plan[i].known_res, produced);
      end
    end

    // largest scale on narrow rows: 400 results of long replays
    write_reg(CFG_SCALE, DIM_W'(MAX_SCALE));
    write_reg(CFG_WIDTH, DIM_W'(2));
    write_reg(CFG_HEIGHT, DIM_W'(2));
    hold_requests++;
    run_phase(400);

    while (random_total < RANDOM_ITEMS) begin
      random_setup();
      if ($urandom_range(0, 3) == 0) begin
        hold_requests++;
      end
      run_phase($urandom_range(20, 120));
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // output side: stall pattern that changes mode at random points,
  // plus long hold-offs on request so the block fills and stalls its input
  // ---------------------------------------------------------------------------
  initial begin : receiver
    stall_mode_e mode;
    int unsigned stretch;
    int unsigned hold_left;
    logic        stall_next;
    out_stall_i  = 1'b0;
    holds_served = 0;
    mode         = STALL_NONE;
    stretch      = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = $urandom_range(40, 90);
      end
      if (stretch == 0) begin
        mode    = stall_mode_e'($urandom_range(0, 3));
        stretch = $urandom_range(10, 200);
      end
      stretch--;
      case (mode)
        STALL_NONE:  stall_next = 1'b0;
        STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
        STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
        default:     stall_next = ~out_stall_i;
      endcase
      if (hold_left != 0) begin
        stall_next = 1'b1;
        hold_left--;
      end
      out_stall_i <= stall_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result checking, in order against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic string fmt_res(input res_t res);
    return $sformatf("b=%02h g=%02h r=%02h copies=%0d pad=%0d row_end=%0b image_end=%0b dropped=%0b",
                     res.blue, res.green, res.red, res.copies, res.pad, res.row_end,
                     res.image_end, res.dropped);
  endfunction

  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.blue      = blue_out_o;
      got.green     = green_out_o;
      got.red       = red_out_o;
      got.copies    = copies_o;
      got.pad       = pad_bytes_o;
      got.row_end   = row_end_o;
      got.image_end = image_end_o;
      got.dropped   = dropped_o;
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: result with none pending: %s", $realtime, fmt_res(got));
        end
      end else begin
        want = pending_pixels.pop_front();
        if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red ||
            got.copies !== want.copies || got.pad !== want.pad ||
            got.row_end !== want.row_end || got.image_end !== want.image_end ||
            got.dropped !== want.dropped) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: expected %s", $realtime, fmt_res(want));
            $display("%0t: actual   %s", $realtime, fmt_res(got));
          end
        end
      end
    end
  end

  // watchdog: any transfer or register write restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    mismatch_count = 0;
    quiet_cycles   = 0;
  end

endmodule

// ===== files.f =====
sv/pru_pkg.sv
sv/pru_front.sv
sv/pru_queue.sv
sv/pixel_replication_upscaler_top.sv
bench/tb_top.sv
